/* design/gcs_pkg.sv */
// shared constants, microcode format, program and weight table of the curve smoother
package gcs_pkg;

   localparam int POINTS       = 256;
   localparam int HALF_WIDTH   = 10;
   localparam int SAMPLE_BITS  = 16;
   localparam int WIN_SIZE     = 2 * HALF_WIDTH + 1;
   localparam int WIN_BITS     = $clog2(WIN_SIZE);
   localparam int POS_BITS     = $clog2(POINTS);
   localparam int OFF_BITS     = $clog2(HALF_WIDTH + 1) + 1;
   localparam int WEIGHT_BITS  = 17;
   localparam int PROD_BITS    = WEIGHT_BITS + SAMPLE_BITS;
   localparam int DEN_BITS     = 19;
   localparam int NUM_BITS     = 35;
   localparam int QUO_BITS     = 16;
   localparam int DIV_CNT_BITS = $clog2(QUO_BITS);
   localparam int STEP_BITS    = 4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_INIT,
      OP_TAP,
      OP_ROUND,
      OP_DIV,
      OP_EMIT,
      OP_NEXT_POINT,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_SKIP,
      COND_TAPS_LEFT,
      COND_DIV_LEFT,
      COND_RSP_BUSY,
      COND_MORE_POINTS
   } cond_type;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_WAIT   = step_type'(0);
   localparam step_type STEP_SETUP  = step_type'(1);
   localparam step_type STEP_INIT   = step_type'(2);
   localparam step_type STEP_TAP    = step_type'(3);
   localparam step_type STEP_DRAIN0 = step_type'(4);
   localparam step_type STEP_DRAIN1 = step_type'(5);
   localparam step_type STEP_ROUND  = step_type'(6);
   localparam step_type STEP_DIV    = step_type'(7);
   localparam step_type STEP_EMIT   = step_type'(8);
   localparam step_type STEP_NEXTPT = step_type'(9);
   localparam step_type STEP_FINISH = step_type'(10);

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic skip;
      logic taps_left;
      logic div_left;
      logic rsp_busy;
      logic more_points;
   } status_type;

   // control program: a jump is taken when its condition holds, else fall through
   function automatic ucode_word_type ucode_rom(input step_type addr);
      ucode_word_type w;
      case (addr)
         STEP_WAIT:   w = '{OP_LOAD,       COND_NO_REQ,      STEP_WAIT};
         STEP_SETUP:  w = '{OP_SETUP,      COND_SKIP,        STEP_FINISH};
         STEP_INIT:   w = '{OP_INIT,       COND_NEXT,        STEP_WAIT};
         STEP_TAP:    w = '{OP_TAP,        COND_TAPS_LEFT,   STEP_TAP};
         STEP_DRAIN0: w = '{OP_NONE,       COND_NEXT,        STEP_WAIT};
         STEP_DRAIN1: w = '{OP_NONE,       COND_NEXT,        STEP_WAIT};
         STEP_ROUND:  w = '{OP_ROUND,      COND_NEXT,        STEP_WAIT};
         STEP_DIV:    w = '{OP_DIV,        COND_DIV_LEFT,    STEP_DIV};
         STEP_EMIT:   w = '{OP_EMIT,       COND_RSP_BUSY,    STEP_EMIT};
         STEP_NEXTPT: w = '{OP_NEXT_POINT, COND_MORE_POINTS, STEP_INIT};
         STEP_FINISH: w = '{OP_FINISH,     COND_ALWAYS,      STEP_WAIT};
         default:     w = '{OP_NONE,       COND_ALWAYS,      STEP_WAIT};
      endcase
      return w;
   endfunction

   // exp(-d*d/8) in q1.16, zeroed below 2^-16 (nonzero out to d = 9)
   function automatic logic [WEIGHT_BITS-1:0] tap_weight(input logic [OFF_BITS-2:0] d);
      logic [WEIGHT_BITS-1:0] w;
      case (d)
         0:       w = WEIGHT_BITS'(65536);
         1:       w = WEIGHT_BITS'(57835);
         2:       w = WEIGHT_BITS'(39750);
         3:       w = WEIGHT_BITS'(21276);
         4:       w = WEIGHT_BITS'(8869);
         5:       w = WEIGHT_BITS'(2879);
         6:       w = WEIGHT_BITS'(728);
         7:       w = WEIGHT_BITS'(143);
         8:       w = WEIGHT_BITS'(22);
         9:       w = WEIGHT_BITS'(3);
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

/* design/gaussian_curve_smoother.sv */
// top level of the gaussian curve smoother
// Curve points enter on the req_ channel, one beat per point, req_last_sample set on the
// final point. Each beat on the rsp_ channel carries one smoothed point, the Gaussian
// weighted average of up to 21 neighbours, rsp_last_result set on the curve's final point.
// A beat moves at a rising edge where valid is high and stall is low.
// Point p comes out while sample p+10 is processed; the final sample releases every
// point still pending, up to 11 beats. A curve ends at 256 points whatever the flag.
// A microcoded sequencer runs the work of each sample: bookkeeping steps, one window tap
// per cycle through the shared multiply-accumulate (up to 21 taps, then the drain steps),
// and the one bit a cycle divider for the 16 quotient bits; a sample that yields no point
// goes from setup straight to finish, and a flush repeats the point steps per point.
// The block takes one sample at a time: req_stall is low only while the sequencer waits
// and reset is low.
// A finished point sits in the output register; while the receiver stalls, the next
// sample is still taken and the sequencer waits only when a second point is ready.
// Synchronous reset empties the output register and starts a new curve; the window store
// is not cleared, as only samples of the current curve are ever read.
module gaussian_curve_smoother (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample_value,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_smoothed_value,
   output logic        rsp_last_result
);

   gcs_pkg::ctrl_type   ctrl;
   gcs_pkg::status_type status;

   gcs_ucode u_ucode (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   gcs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_value   (req_sample_value),
      .req_last_sample    (req_last_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

/* design/gcs_ram.sv */
// generic single write port ram with registered read
module gcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gcs_ucode.sv */
// microcode sequencer: step counter, control rom and jump conditions
module gcs_ucode (
   input  logic                clock,
   input  logic                reset,
   input  gcs_pkg::status_type status,
   output gcs_pkg::ctrl_type   ctrl
);

   gcs_pkg::step_type       upc_ff;
   gcs_pkg::step_type       upc_in;
   gcs_pkg::ucode_word_type word;
   logic                    taken;

   assign word = gcs_pkg::ucode_rom(upc_ff);

   always_comb begin
      case (word.cond)
         gcs_pkg::COND_NEXT:        taken = 1'b0;
         gcs_pkg::COND_ALWAYS:      taken = 1'b1;
         gcs_pkg::COND_NO_REQ:      taken = !status.req_valid;
         gcs_pkg::COND_SKIP:        taken = status.skip;
         gcs_pkg::COND_TAPS_LEFT:   taken = status.taps_left;
         gcs_pkg::COND_DIV_LEFT:    taken = status.div_left;
         gcs_pkg::COND_RSP_BUSY:    taken = status.rsp_busy;
         gcs_pkg::COND_MORE_POINTS: taken = status.more_points;
         default:                   taken = 1'b1;
      endcase
      upc_in = taken ? word.target : upc_ff + gcs_pkg::STEP_BITS'(1);
   end

   always_comb begin
      ctrl.op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= gcs_pkg::STEP_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* design/gcs_datapath.sv */
// window store, tap multiply-accumulate, serial divider and result register
module gcs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  gcs_pkg::ctrl_type                  ctrl,
   output gcs_pkg::status_type                status,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [15:0]                        req_sample_value,
   input  logic                               req_last_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [15:0]                        rsp_smoothed_value,
   output logic                               rsp_last_result
);

   localparam int PB = gcs_pkg::POS_BITS;
   localparam int WB = gcs_pkg::WIN_BITS;
   localparam int OB = gcs_pkg::OFF_BITS;
   localparam int SAMPLE_W = gcs_pkg::SAMPLE_BITS;

   // control state
   logic [PB-1:0] samples_ff, samples_in;
   logic [PB-1:0] results_ff, results_in;
   logic [WB-1:0] wr_ptr_ff, wr_ptr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          s1_valid_ff, s2_valid_ff;
   logic          last_ff, last_in;

   // working registers
   logic [PB-1:0]                      p_ff, p_in;
   logic [PB-1:0]                      j_ff, j_in;
   logic [PB-1:0]                      hi_ff, hi_in;
   logic signed [OB-1:0]               off_ff, off_in;
   logic [WB-1:0]                      ridx_ff, ridx_in;
   logic [gcs_pkg::WEIGHT_BITS-1:0]    s1_w_ff, s1_w_in, s2_w_ff;
   logic [gcs_pkg::PROD_BITS-1:0]      prod_ff;
   logic [gcs_pkg::NUM_BITS-1:0]       num_ff, num_in;
   logic [gcs_pkg::DEN_BITS-1:0]       den_ff, den_in;
   logic [gcs_pkg::DEN_BITS-1:0]       rem_ff, rem_in;
   logic [gcs_pkg::QUO_BITS-1:0]       dlo_ff, dlo_in;
   logic [gcs_pkg::DIV_CNT_BITS-1:0]   div_cnt_ff, div_cnt_in;
   logic [15:0]                        rsp_value_ff, rsp_value_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               load_fire;
   logic                               emit_fire;
   logic [SAMPLE_W-1:0]                rd_data;
   logic [PB-1:0]                      lo;
   logic [PB:0]                        hi_sum;
   logic [PB-1:0]                      back;
   logic [PB-1:0]                      back_p;
   logic [WB:0]                        ridx_wide;
   logic [OB-2:0]                      mag;
   logic [gcs_pkg::NUM_BITS-1:0]       dvd;
   logic [gcs_pkg::DEN_BITS:0]         trial;
   logic                               ge;

   assign req_stall = reset || (ctrl.op != gcs_pkg::OP_LOAD);
   assign load_fire = req_valid && !req_stall;
   assign emit_fire = (ctrl.op == gcs_pkg::OP_EMIT) && !status.rsp_busy;

   gcs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (gcs_pkg::WIN_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_sample_value[SAMPLE_W-1:0]),
      .rd_addr (ridx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      status.req_valid   = req_valid;
      status.skip        = !last_ff && (samples_ff < PB'(gcs_pkg::HALF_WIDTH));
      status.taps_left   = (j_ff != hi_ff);
      status.div_left    = (div_cnt_ff != '0);
      status.rsp_busy    = rsp_valid_ff && rsp_stall;
      status.more_points = last_ff && (p_ff != samples_ff);
   end

   // window bounds for the point in p_ff
   always_comb begin
      lo = (p_ff >= PB'(gcs_pkg::HALF_WIDTH)) ? p_ff - PB'(gcs_pkg::HALF_WIDTH) : '0;
      hi_sum = {1'b0, p_ff} + (PB + 1)'(gcs_pkg::HALF_WIDTH);
      back   = samples_ff - lo;
      back_p = p_ff - lo;
      // ring slot of lo, counted back from the slot of the newest sample
      if ({1'b0, wr_ptr_ff} >= (WB + 1)'(back)) begin
         ridx_wide = {1'b0, wr_ptr_ff} - (WB + 1)'(back);
      end else begin
         ridx_wide = {1'b0, wr_ptr_ff} + (WB + 1)'(gcs_pkg::WIN_SIZE) - (WB + 1)'(back);
      end
      mag = off_ff[OB-1] ? (OB - 1)'(-off_ff) : off_ff[OB-2:0];
   end

   always_comb begin
      dvd   = num_ff + gcs_pkg::NUM_BITS'(den_ff >> 1);
      trial = {rem_ff, dlo_ff[gcs_pkg::QUO_BITS-1]};
      ge    = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      samples_in   = samples_ff;
      results_in   = results_ff;
      wr_ptr_in    = wr_ptr_ff;
      last_in      = last_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      hi_in        = hi_ff;
      off_in       = off_ff;
      ridx_in      = ridx_ff;
      s1_w_in      = gcs_pkg::tap_weight(mag);
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dlo_in       = dlo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (s2_valid_ff) begin
         num_in = num_ff + gcs_pkg::NUM_BITS'(prod_ff);
         den_in = den_ff + gcs_pkg::DEN_BITS'(s2_w_ff);
      end

      case (ctrl.op)
         gcs_pkg::OP_LOAD: begin
            if (load_fire) begin
               // an overlong curve ends at its last position
               last_in = req_last_sample || (samples_ff == PB'(gcs_pkg::POINTS - 1));
            end
         end
         gcs_pkg::OP_SETUP: begin
            p_in = last_ff ? results_ff : samples_ff - PB'(gcs_pkg::HALF_WIDTH);
         end
         gcs_pkg::OP_INIT: begin
            num_in  = '0;
            den_in  = '0;
            j_in    = lo;
            hi_in   = (hi_sum > {1'b0, samples_ff}) ? samples_ff : hi_sum[PB-1:0];
            off_in  = OB'(0) - OB'(back_p);
            ridx_in = ridx_wide[WB-1:0];
         end
         gcs_pkg::OP_TAP: begin
            j_in    = j_ff + PB'(1);
            off_in  = off_ff + OB'(1);
            ridx_in = (ridx_ff == WB'(gcs_pkg::WIN_SIZE - 1)) ? '0 : ridx_ff + WB'(1);
         end
         gcs_pkg::OP_ROUND: begin
            rem_in     = dvd[gcs_pkg::NUM_BITS-1:gcs_pkg::QUO_BITS];
            dlo_in     = dvd[gcs_pkg::QUO_BITS-1:0];
            div_cnt_in = gcs_pkg::DIV_CNT_BITS'(gcs_pkg::QUO_BITS - 1);
         end
         gcs_pkg::OP_DIV: begin
            rem_in     = ge ? gcs_pkg::DEN_BITS'(trial - {1'b0, den_ff})
                            : trial[gcs_pkg::DEN_BITS-1:0];
            dlo_in     = {dlo_ff[gcs_pkg::QUO_BITS-2:0], ge};
            div_cnt_in = div_cnt_ff - gcs_pkg::DIV_CNT_BITS'(1);
         end
         gcs_pkg::OP_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = dlo_ff[15:0];
               rsp_last_in  = last_ff && (p_ff == samples_ff);
               results_in   = results_ff + PB'(1);
            end
         end
         gcs_pkg::OP_NEXT_POINT: begin
            p_in = p_ff + PB'(1);
         end
         gcs_pkg::OP_FINISH: begin
            if (last_ff) begin
               samples_in = '0;
               results_in = '0;
               wr_ptr_in  = '0;
            end else begin
               samples_in = samples_ff + PB'(1);
               wr_ptr_in  = (wr_ptr_ff == WB'(gcs_pkg::WIN_SIZE - 1)) ? '0
                                                                      : wr_ptr_ff + WB'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff   <= '0;
         results_ff   <= '0;
         wr_ptr_ff    <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         samples_ff   <= samples_in;
         results_ff   <= results_in;
         wr_ptr_ff    <= wr_ptr_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= (ctrl.op == gcs_pkg::OP_TAP);
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   // tap pipe: read issue, product, accumulate
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      j_ff         <= j_in;
      hi_ff        <= hi_in;
      off_ff       <= off_in;
      ridx_ff      <= ridx_in;
      s1_w_ff      <= s1_w_in;
      s2_w_ff      <= s1_w_ff;
      prod_ff      <= s1_w_ff * rd_data;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      dlo_ff       <= dlo_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_value = rsp_value_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule
